// ===== design/assert_macros.svh =====
// assertion helpers included by cpg_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== design/cpg_pkg.sv =====
package cpg_pkg;

    typedef logic signed [15:0] t_torque;

    typedef struct packed {
        logic [15:0] elapsed_time;
        logic        run_enable;
    } t_in_item;

    typedef struct packed {
        t_torque elbow_one;
        t_torque axle_one;
        t_torque elbow_two;
        t_torque axle_two;
        t_torque elbow_three;
        t_torque axle_three;
        t_torque elbow_four;
        t_torque axle_four;
    } t_out_item;

    // configuration register indexes
    localparam logic [2:0] CFG_TURN_RATE   = 3'd0;
    localparam logic [2:0] CFG_PHASE_LEG_A = 3'd1;
    localparam logic [2:0] CFG_PHASE_LEG_B = 3'd2;
    localparam logic [2:0] CFG_PHASE_LEG_C = 3'd3;
    localparam logic [2:0] CFG_PHASE_LEG_D = 3'd4;

    // multiply steps of one leg
    localparam logic [2:0] STEP_SQUARE       = 3'd0;
    localparam logic [2:0] STEP_HORNER_FIRST = 3'd1;
    localparam logic [2:0] STEP_HORNER_LAST  = 3'd4;
    localparam logic [2:0] STEP_SINE         = 3'd5;
    localparam logic [2:0] STEP_SCALE        = 3'd6;

    localparam logic [1:0] LEG_LAST = 2'd3;

    // quarter sine polynomial in q30, constant term first
    localparam logic [30:0] POLY_COEF [0:4] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026996, 31'd172272
    };
    localparam logic [2:0] COEF_TOP = 3'd4;

    // amplitude 10 in units of 1/2048
    localparam logic [14:0] TORQUE_FULL = 15'd20480;
    localparam logic [62:0] ROUND_HALF  = 63'h0000_0000_2000_0000;

    typedef struct packed {
        logic       load_in;
        logic       rate_mul;
        logic       acc_add;
        logic       setup;
        logic       leg_mul;
        logic       leg_use;
        logic [2:0] step;
        logic [1:0] leg;
        logic       out_load;
    } t_dp_cmd;

endpackage

// ===== design/four_phase_sine_gait_generator.sv =====
// four-leg sine gait generator: each accepted tick with run_enable set adds
// turn_rate * elapsed_time to a wrapping 32-bit phase (2^-32 turn) and gives one
// item of eight joint torques (units 1/2048, amplitude 10): the waves of legs
// a..d at phase + leg phase, then the waves of d, c, a, b negated; a tick
// with run_enable clear is taken and dropped with no item out. a running
// tick does the rate product and the phase add, then per leg a setup and
// seven products (square, four horner steps, sine, amplitude scale), each
// a multiply state then a use state, legs in turn, on one shared 31x31
// multiplier with a registered product, until its item is loaded into the
// output register. the next tick is taken once the previous result sits in
// the output register, even while that result is still stalled. configuration
// writes are meant for idle times only; unknown register indexes are ignored
module four_phase_sine_gait_generator #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // tick items in
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cpg_pkg::t_in_item  i_in_item,
    // torque items out
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cpg_pkg::t_out_item o_out_item
);
    import cpg_pkg::*;

    t_dp_cmd cmd;

    // sequencer: owns handshake and output valid
    cpg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_run_enable (i_in_item.run_enable),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    // registers, phase accumulator, shared multiplier and output register
    cpg_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/cpg_datapath.sv =====
module cpg_datapath #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  cpg_pkg::t_in_item  i_in_item,
    input  cpg_pkg::t_dp_cmd   i_cmd,
    output cpg_pkg::t_out_item o_out_item
);
    import cpg_pkg::*;

    localparam int FracW = SINE_TABLE_BITS - 2;
    localparam int ShiftW = 32 - SINE_TABLE_BITS;
    localparam logic [FracW:0] FracOne = {1'b1, {FracW{1'b0}}};

    logic [23:0] r_rate;
    logic [15:0] r_leg_phase [4];
    logic [15:0] r_dt;
    logic [31:0] r_acc;
    logic [30:0] r_u;
    logic [30:0] r_u2;
    logic [30:0] r_p;
    logic [30:0] r_s;
    logic [1:0]  r_quad;
    logic [61:0] r_prod;
    t_torque     r_wave [4];
    t_out_item   r_out;

    logic [31:0] angle;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [FracW:0] frac_ext;
    logic [FracW:0] frac_m;
    logic [30:0] n_u;
    logic [30:0] mul_a;
    logic [30:0] mul_b;
    logic [31:0] horner_sub;
    logic [62:0] round_sum;
    logic [32:0] mag_full;
    logic [14:0] mag;
    t_torque     n_wave;

    // phase lookup for the leg being set up
    always_comb begin
        angle    = r_acc + {r_leg_phase[i_cmd.leg], 16'h0000};
        idx      = angle[31 -: SINE_TABLE_BITS];
        frac_ext = {1'b0, idx[FracW-1:0]};
        frac_m   = idx[FracW] ? (FracOne - frac_ext) : frac_ext;
        n_u      = {frac_m, {ShiftW{1'b0}}};
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = r_u;
        mul_b = r_u;
        if (i_cmd.rate_mul) begin
            mul_a = {7'd0, r_rate};
            mul_b = {15'd0, r_dt};
        end else begin
            case (i_cmd.step)
                STEP_SQUARE: begin
                    mul_a = r_u;
                    mul_b = r_u;
                end
                STEP_SINE: begin
                    mul_a = r_u;
                    mul_b = r_p;
                end
                STEP_SCALE: begin
                    mul_a = r_s;
                    mul_b = {16'd0, TORQUE_FULL};
                end
                default: begin
                    mul_a = r_u2;
                    mul_b = r_p;
                end
            endcase
        end
    end

    // post-multiply arithmetic
    always_comb begin
        horner_sub = {1'b0, POLY_COEF[COEF_TOP - i_cmd.step]} - r_prod[61:30];
        round_sum  = {1'b0, r_prod} + ROUND_HALF;
        mag_full   = round_sum[62:30];
        mag        = (mag_full > {18'd0, TORQUE_FULL}) ? TORQUE_FULL : mag_full[14:0];
        n_wave     = r_quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
            for (int i = 0; i < 4; i++) begin
                r_leg_phase[i] <= '0;
            end
            r_acc <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TURN_RATE:   r_rate         <= i_cfg_data;
                    CFG_PHASE_LEG_A: r_leg_phase[0] <= i_cfg_data[15:0];
                    CFG_PHASE_LEG_B: r_leg_phase[1] <= i_cfg_data[15:0];
                    CFG_PHASE_LEG_C: r_leg_phase[2] <= i_cfg_data[15:0];
                    CFG_PHASE_LEG_D: r_leg_phase[3] <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.acc_add) begin
                r_acc <= r_acc + r_prod[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dt <= i_in_item.elapsed_time;
        end
        if (i_cmd.rate_mul || i_cmd.leg_mul) begin
            r_prod <= 62'(mul_a) * 62'(mul_b);
        end
        if (i_cmd.setup) begin
            r_u    <= n_u;
            r_quad <= idx[SINE_TABLE_BITS-1 -: 2];
            r_p    <= POLY_COEF[COEF_TOP];
        end
        if (i_cmd.leg_use) begin
            if (i_cmd.step == STEP_SQUARE) begin
                r_u2 <= r_prod[60:30];
            end else if (i_cmd.step inside {[STEP_HORNER_FIRST:STEP_HORNER_LAST]}) begin
                r_p <= horner_sub[30:0];
            end else if (i_cmd.step == STEP_SINE) begin
                r_s <= r_prod[60:30];
            end else begin
                r_wave[i_cmd.leg] <= n_wave;
            end
        end
        if (i_cmd.out_load) begin
            r_out.elbow_one   <= r_wave[0];
            r_out.axle_one    <= r_wave[1];
            r_out.elbow_two   <= r_wave[2];
            r_out.axle_two    <= r_wave[3];
            r_out.elbow_three <= -r_wave[3];
            r_out.axle_three  <= -r_wave[2];
            r_out.elbow_four  <= -r_wave[0];
            r_out.axle_four   <= -r_wave[1];
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== design/cpg_ctrl.sv =====
`include "assert_macros.svh"

module cpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_run_enable,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output cpg_pkg::t_dp_cmd o_cmd
);
    import cpg_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RATE_MUL = 3'd1;
    localparam logic [2:0] S_ACC_ADD  = 3'd2;
    localparam logic [2:0] S_SETUP    = 3'd3;
    localparam logic [2:0] S_MUL      = 3'd4;
    localparam logic [2:0] S_USE      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_leg, n_leg;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    cmd;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_leg       = r_leg;
        cmd         = '0;
        cmd.step    = r_step;
        cmd.leg     = r_leg;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    if (i_run_enable) begin
                        n_state = S_RATE_MUL;
                    end
                end
            end
            S_RATE_MUL: begin
                cmd.rate_mul = 1'b1;
                n_state      = S_ACC_ADD;
            end
            S_ACC_ADD: begin
                cmd.acc_add = 1'b1;
                n_leg       = '0;
                n_state     = S_SETUP;
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_step    = STEP_SQUARE;
                n_state   = S_MUL;
            end
            S_MUL: begin
                cmd.leg_mul = 1'b1;
                n_state     = S_USE;
            end
            S_USE: begin
                cmd.leg_use = 1'b1;
                if (r_step == STEP_SCALE) begin
                    if (r_leg == LEG_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_leg   = r_leg + 2'd1;
                        n_state = S_SETUP;
                    end
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_SQUARE;
            r_leg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_leg       <= n_leg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, cmd.out_load && r_out_valid && i_out_stall)
    `ASSERT_NEVER(a_step_range, i_clk, i_rst_n, r_step > STEP_SCALE)
    `ASSERT_PROP(a_last_leg_done, i_clk, i_rst_n, (r_state == S_USE && r_step == STEP_SCALE && r_leg == LEG_LAST) |=> (r_state == S_DONE))
    `ASSERT_PROP(a_held_result, i_clk, i_rst_n, (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE && r_out_valid))

endmodule
